// ===== rtl/rlh_pkg.sv =====
// Shared types and codes for the request latency log2 histogram unit.
// No dependencies.
package rlh_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DONE  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DROPPED   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ENT_EMPTY = 2'd0,
    ENT_VALID = 2'd1,
    ENT_TOMB  = 2'd2
  } ent_state_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_TRD,
    S_TCHK,
    S_LOG,
    S_HRD,
    S_HUPD
  } eng_state_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] tag;
    logic [63:0] now;
    logic [5:0]  bidx;
  } cmd_t;

  typedef struct packed {
    ent_state_e  st;
    logic [63:0] tag;
    logic [63:0] tm;
  } ent_t;

endpackage

// ===== rtl/request_latency_log2_histogram_unit.sv =====
// Top level of the request latency log2 histogram unit.
// Depends on rlh_pkg, rlh_front and rlh_engine.
//
//  channel | signals                                         | dir
//  in      | in_valid_i/in_ready_o, opcode, tag, now, bucket | in
//  out     | out_valid_o/out_ready_i, status, slot, count    | out
//
// Start/done probe the table by open addressing with linear probing from a folded tag
// hash, up to TABLE_ENTRIES - 1 extra probes. Done then takes the log2 of the latency
// and updates the histogram. Read returns one histogram bucket; opcode 3 returns OK.
// After reset a clearing pass sweeps every table entry; items queue in the
// two-entry front queue meanwhile. A held result stalls the back.
module request_latency_log2_histogram_unit import rlh_pkg::*; #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int HIST_BUCKETS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] request_tag_i,
  input  logic [63:0] now_ns_i,
  input  logic [5:0]  bucket_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_hit_o,
  output logic [63:0] bucket_count_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  rlh_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .request_tag_i,
    .now_ns_i, .bucket_index_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rlh_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .HIST_BUCKETS  (HIST_BUCKETS)
  ) u_engine (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o, .out_ready_i, .status_o, .slot_hit_o, .bucket_count_o
  );

endmodule

// ===== rtl/rlh_front.sv =====
// Front end: accepts items, decodes the opcode and queues commands.
// Depends on rlh_pkg.
module rlh_front import rlh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] request_tag_i,
  input  logic [63:0] now_ns_i,
  input  logic [5:0]  bucket_index_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       dec;

  always_comb begin
    dec.op   = op_e'(opcode_i);
    dec.tag  = request_tag_i;
    dec.now  = now_ns_i;
    dec.bidx = bucket_index_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (cmd_pop_i) rptr_q <= ~rptr_q;
      unique case ({push, cmd_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/rlh_engine.sv =====
// Back end: hashed request table with linear probing, latency log2 and
// histogram update. Depends on rlh_pkg.
module rlh_engine import rlh_pkg::*; #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int HIST_BUCKETS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_hit_o,
  output logic [63:0] bucket_count_o
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int HB_W  = $clog2(HIST_BUCKETS);
  localparam logic [IDX_W:0]   NumEnt  = (IDX_W+1)'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LastEnt = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [6:0]       NumHb   = 7'(HIST_BUCKETS);

  function automatic logic [6:0] flog2(input logic [63:0] v);
    logic [6:0] r;
    r = 7'd0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) r = 7'(i);
    end
    return r;
  endfunction

  ent_t mem [TABLE_ENTRIES];
  logic [63:0] hmem [HIST_BUCKETS];

  eng_state_e state_q, state_d;
  cmd_t       cmd_q, cmd_d;
  logic [IDX_W-1:0] probe_q, probe_d, visit_q, visit_d, tomb_q, tomb_d, clr_q, clr_d;
  logic             tomb_found_q, tomb_found_d;
  logic [IDX_W:0]   cnt_q, cnt_d;
  ent_t             rd_q;
  logic [63:0]      delta_q, delta_d;
  logic [HB_W-1:0]  hidx_q, hidx_d;
  logic [63:0]      hrd_q;
  logic [HIST_BUCKETS-1:0] hval_q;
  logic             res_v_q, res_v_d;
  status_e          res_st_q, res_st_d;
  logic [5:0]       res_slot_q, res_slot_d;
  logic [63:0]      res_cnt_q, res_cnt_d;

  logic             we;
  logic [IDX_W-1:0] waddr;
  ent_t             wdata;
  logic             hwe;
  logic [63:0]      hwdata;
  logic [15:0]      fold;
  logic [IDX_W-1:0] home, nxt, free_idx;
  logic [6:0]       lg, slot;
  logic             hit, miss, done_go;
  logic [63:0]      hcur;

  assign fold = cmd_i.tag[15:0] ^ cmd_i.tag[31:16] ^ cmd_i.tag[47:32] ^ cmd_i.tag[63:48];
  always_comb begin
    home = fold[IDX_W-1:0];
    if ({1'b0, home} >= NumEnt) home = home - NumEnt[IDX_W-1:0];
  end
  assign nxt      = (probe_q == LastEnt) ? '0 : probe_q + 1'b1;
  assign hit      = (rd_q.st == ENT_VALID) && (rd_q.tag == cmd_q.tag);
  assign miss     = !hit && ((rd_q.st == ENT_EMPTY) || (visit_q == LastEnt));
  assign free_idx = tomb_found_q ? tomb_q : probe_q;
  assign lg       = flog2(delta_q);
  assign slot     = (lg >= NumHb) ? NumHb - 7'd1 : lg;
  assign hcur     = hval_q[hidx_q] ? hrd_q : 64'd0;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i && !res_v_q;
  assign done_go   = cmd_pop_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == LastEnt) state_d = S_IDLE;
      S_IDLE: begin
        if (done_go) begin
          unique case (cmd_i.op)
            OP_START, OP_DONE: state_d = S_TRD;
            OP_READ:  if ({1'b0, cmd_i.bidx} < NumHb) state_d = S_HRD;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_TRD:  state_d = S_TCHK;
      S_TCHK: begin
        if (hit && cmd_q.op == OP_DONE) state_d = S_LOG;
        else if (hit || miss) state_d = S_IDLE;
        else state_d = S_TRD;
      end
      S_LOG:  state_d = S_HRD;
      S_HRD:  state_d = S_HUPD;
      S_HUPD: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d        = cmd_q;
    probe_d      = probe_q;
    visit_d      = visit_q;
    tomb_d       = tomb_q;
    tomb_found_d = tomb_found_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    delta_d      = delta_q;
    hidx_d       = hidx_q;
    res_v_d      = res_v_q && !out_ready_i;
    res_st_d     = res_st_q;
    res_slot_d   = res_slot_q;
    res_cnt_d    = res_cnt_q;
    we           = 1'b0;
    waddr        = probe_q;
    wdata        = rd_q;
    hwe          = 1'b0;
    hwdata       = hcur + 64'd1;
    unique case (state_q)
      S_CLR: begin
        we       = 1'b1;
        waddr    = clr_q;
        wdata.st = ENT_EMPTY;
        clr_d    = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (done_go) begin
          cmd_d        = cmd_i;
          probe_d      = home;
          visit_d      = '0;
          tomb_found_d = 1'b0;
          hidx_d       = cmd_i.bidx[HB_W-1:0];
          if (cmd_i.op == OP_NONE ||
              (cmd_i.op == OP_READ && {1'b0, cmd_i.bidx} >= NumHb)) begin
            res_v_d    = 1'b1;
            res_st_d   = ST_OK;
            res_slot_d = '0;
            res_cnt_d  = '0;
          end
        end
      end
      S_TCHK: begin
        if (hit) begin
          if (cmd_q.op == OP_START) begin
            we       = 1'b1;
            wdata.tm = cmd_q.now;
            res_v_d    = 1'b1;
            res_st_d   = ST_OK;
            res_slot_d = '0;
            res_cnt_d  = '0;
          end else begin
            we       = 1'b1;
            wdata.st = ENT_TOMB;
            cnt_d    = cnt_q - 1'b1;
            delta_d  = cmd_q.now - rd_q.tm;
          end
        end else if (miss) begin
          res_v_d    = 1'b1;
          res_slot_d = '0;
          res_cnt_d  = '0;
          if (cmd_q.op == OP_DONE) begin
            res_st_d = ST_NOT_FOUND;
          end else if (cnt_q == NumEnt) begin
            res_st_d = ST_DROPPED;
          end else begin
            res_st_d  = ST_OK;
            we        = 1'b1;
            waddr     = free_idx;
            wdata.st  = ENT_VALID;
            wdata.tag = cmd_q.tag;
            wdata.tm  = cmd_q.now;
            cnt_d     = cnt_q + 1'b1;
          end
        end else begin
          if (rd_q.st == ENT_TOMB && !tomb_found_q) begin
            tomb_found_d = 1'b1;
            tomb_d       = probe_q;
          end
          probe_d = nxt;
          visit_d = visit_q + 1'b1;
        end
      end
      S_LOG: hidx_d = slot[HB_W-1:0];
      S_HUPD: begin
        res_v_d  = 1'b1;
        res_st_d = ST_OK;
        if (cmd_q.op == OP_DONE) begin
          hwe        = 1'b1;
          res_slot_d = 6'(hidx_q);
          res_cnt_d  = '0;
        end else begin
          res_slot_d = '0;
          res_cnt_d  = hcur;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[probe_q];
    if (hwe) hmem[hidx_q] <= hwdata;
    hrd_q <= hmem[hidx_q];
  end

  always_ff @(posedge clk_i) begin
    cmd_d_reg: begin
      cmd_q      <= cmd_d;
      probe_q    <= probe_d;
      visit_q    <= visit_d;
      tomb_q     <= tomb_d;
      delta_q    <= delta_d;
      hidx_q     <= hidx_d;
      res_st_q   <= res_st_d;
      res_slot_q <= res_slot_d;
      res_cnt_q  <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      cnt_q        <= '0;
      tomb_found_q <= 1'b0;
      hval_q       <= '0;
      res_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      cnt_q        <= cnt_d;
      tomb_found_q <= tomb_found_d;
      if (hwe) hval_q[hidx_q] <= 1'b1;
      res_v_q      <= res_v_d;
    end
  end

  assign out_valid_o    = res_v_q;
  assign status_o       = res_st_q;
  assign slot_hit_o     = res_slot_q;
  assign bucket_count_o = res_cnt_q;

endmodule

// ===== rtl/rlh_checker.sv =====
// Port-level checks for the request latency log2 histogram unit, bound to top.
// Depends on rlh_pkg.
module rlh_checker import rlh_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [5:0]  slot_hit_o,
  input logic [63:0] bucket_count_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(slot_hit_o) && $stable(bucket_count_o))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NOT_FOUND || status_o == ST_DROPPED) |->
    slot_hit_o == 6'd0 && bucket_count_o == 64'd0)
    else $error("failed item carries data");

  a_slot_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_hit_o != 6'd0 |-> bucket_count_o == 64'd0)
    else $error("slot and count both set");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status");

endmodule

bind request_latency_log2_histogram_unit rlh_checker u_rlh_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .status_o, .slot_hit_o,
  .bucket_count_o
);

// ===== tb/tb_request_latency_log2_histogram_unit.sv =====
// Self-checking testbench for request_latency_log2_histogram_unit: directed table
// then random start/done/read/opcode-3 traffic against a behavioral table and histogram.
// Depends on rlh_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb_request_latency_log2_histogram_unit import rlh_pkg::*; ();

  localparam int ENTRIES = 4096;
  localparam int BUCKETS = 64;
  localparam int N_RAND  = 470;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [63:0] count;
  } result_t;

  typedef struct {
    op_e         op;
    logic [63:0] tag;
    logic [63:0] now;
    logic [5:0]  bidx;
    bit          fixed;
    result_t     res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [63:0] request_tag_i = '0;
  logic [63:0] now_ns_i = '0;
  logic [5:0]  bucket_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [5:0]  slot_hit_o;
  logic [63:0] bucket_count_o;

  request_latency_log2_histogram_unit dut (.*);

  // behavioral state
  bit          live_q[ENTRIES];
  logic [63:0] tag_q[ENTRIES];
  logic [63:0] start_q[ENTRIES];
  logic [63:0] hist_q[BUCKETS];

  result_t     expected_q[$];
  logic [63:0] tag_pool[$];
  int          errors = 0;
  int          n_results = 0;
  int          n_drops = 0;
  int          n_hits = 0;
  longint unsigned cycles = 0;
  bit          quiet = 1'b0;
  bit          in_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int log2_floor(logic [63:0] v);
    int r;
    r = 0;
    for (int b = 63; b > 0; b--) begin
      if (v[b] && r == 0) r = b;
    end
    return r;
  endfunction

  function automatic result_t latency_update(op_e op, logic [63:0] tag, logic [63:0] now,
                                             logic [5:0] bidx);
    result_t r;
    int hit;
    int slot;
    int free;
    r = '0;
    hit = -1;
    free = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (live_q[i] && tag_q[i] == tag && hit < 0) hit = i;
      if (!live_q[i] && free < 0) free = i;
    end
    case (op)
      OP_START: begin
        if (hit >= 0) start_q[hit] = now;
        else if (free < 0) r.status = ST_DROPPED;
        else begin
          live_q[free] = 1'b1;
          tag_q[free] = tag;
          start_q[free] = now;
        end
      end
      OP_DONE: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          slot = log2_floor(now - start_q[hit]);
          if (slot >= BUCKETS) slot = BUCKETS - 1;
          live_q[hit] = 1'b0;
          hist_q[slot] = hist_q[slot] + 1;
          r.slot = slot[5:0];
        end
      end
      OP_READ: begin
        if (bidx < BUCKETS) r.count = hist_q[bidx];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(op_e op, logic [63:0] tag, logic [63:0] now, logic [5:0] bidx);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    request_tag_i <= tag;
    now_ns_i <= now;
    bucket_index_i <= bidx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic issue(op_e op, logic [63:0] tag, logic [63:0] now, logic [5:0] bidx);
    result_t r;
    r = latency_update(op, tag, now, bidx);
    if (r.status == ST_DROPPED) n_drops++;
    if (op == OP_DONE && r.status == ST_OK) n_hits++;
    expected_q.push_back(r);
    send(op, tag, now, bidx);
  endtask

  // receiver with random stall bursts
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 12);
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status=%0d", status_o);
      end else begin
        want = expected_q.pop_front();
        if (status_o !== want.status || slot_hit_o !== want.slot ||
            bucket_count_o !== want.count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d slot=%0d cnt=%0h got st=%0d slot=%0d cnt=%0h",
                     want.status, want.slot, want.count, status_o, slot_hit_o,
                     bucket_count_o);
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    row_t dir_rows[$];
    row_t row;
    result_t got;
    logic [63:0] tag;
    logic [63:0] t0;
    int pick;
    int wait_cnt;
    foreach (live_q[i]) live_q[i] = 1'b0;
    foreach (hist_q[i]) hist_q[i] = '0;

    // directed rows; fixed results are checked against the predictor too
    dir_rows.push_back('{OP_READ, 64'd0, 64'd0, 6'd0, 1'b1, '{ST_OK, 6'd0, 64'd0}});
    dir_rows.push_back('{OP_DONE, 64'd5, 64'd9, 6'd0, 1'b1, '{ST_NOT_FOUND, 6'd0, 64'd0}});
    dir_rows.push_back('{OP_START, 64'd1, 64'd100, 6'd0, 1'b0, '0});
    dir_rows.push_back('{OP_DONE, 64'd1, 64'd100, 6'd0, 1'b1, '{ST_OK, 6'd0, 64'd0}});
    dir_rows.push_back('{OP_START, '1, 64'd0, 6'd0, 1'b0, '0});
    dir_rows.push_back('{OP_START, '1, 64'd10, 6'd63, 1'b0, '0});
    dir_rows.push_back('{OP_DONE, '1, '1, 6'd0, 1'b1, '{ST_OK, 6'd63, 64'd0}});
    dir_rows.push_back('{OP_START, 64'd2, '1, 6'd0, 1'b0, '0});
    dir_rows.push_back('{OP_DONE, 64'd2, 64'd0, 6'd0, 1'b1, '{ST_OK, 6'd0, 64'd0}});
    dir_rows.push_back('{OP_START, 64'd3, 64'd7, 6'd0, 1'b0, '0});
    dir_rows.push_back('{OP_DONE, 64'd3, 64'd6, 6'd0, 1'b1, '{ST_OK, 6'd63, 64'd0}});
    dir_rows.push_back('{OP_START, 64'd4, 64'd0, 6'd0, 1'b0, '0});
    dir_rows.push_back('{OP_DONE, 64'd4, 64'd2, 6'd0, 1'b1, '{ST_OK, 6'd1, 64'd0}});
    dir_rows.push_back('{OP_DONE, 64'd4, 64'd2, 6'd0, 1'b1, '{ST_NOT_FOUND, 6'd0, 64'd0}});
    dir_rows.push_back('{OP_NONE, '1, '1, 6'h3f, 1'b1, '{ST_OK, 6'd0, 64'd0}});
    dir_rows.push_back('{OP_READ, '1, '1, 6'd0, 1'b1, '{ST_OK, 6'd0, 64'd2}});
    dir_rows.push_back('{OP_READ, 64'd0, 64'd0, 6'd63, 1'b1, '{ST_OK, 6'd0, 64'd2}});
    dir_rows.push_back('{OP_READ, 64'd0, 64'd0, 6'd1, 1'b1, '{ST_OK, 6'd0, 64'd1}});
    dir_rows.push_back('{OP_READ, 64'd0, 64'd0, 6'd2, 1'b0, '0});

    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      got = latency_update(row.op, row.tag, row.now, row.bidx);
      if (row.fixed && got !== row.res) begin
        errors++;
        if (errors <= 10) $display("directed row %0d disagrees with prediction", i);
      end
      expected_q.push_back(got);
      send(row.op, row.tag, row.now, row.bidx);
    end

    // random: mostly start/done pairs on a small live pool, some noise
    for (int n = 0; n < N_RAND; n++) begin
      if (n > N_RAND - 60) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 35 || tag_pool.size() == 0) begin
        tag = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 40));
        tag_pool.push_back(tag);
        issue(OP_START, tag, rand64() >> $urandom_range(0, 63), 6'($urandom()));
      end else if (pick < 75) begin
        pick = $urandom_range(0, tag_pool.size() - 1);
        tag = tag_pool[pick];
        tag_pool.delete(pick);
        t0 = 64'd0;
        for (int i = 0; i < ENTRIES; i++) if (live_q[i] && tag_q[i] == tag) t0 = start_q[i];
        issue(OP_DONE, tag, t0 + (rand64() >> $urandom_range(0, 63)), 6'($urandom()));
      end else if (pick < 88) begin
        issue(OP_READ, rand64(), rand64(), 6'($urandom()));
      end else if (pick < 95) begin
        issue(OP_DONE, rand64(), rand64(), 6'($urandom()));
      end else begin
        issue(OP_NONE, rand64(), rand64(), 6'($urandom()));
      end
    end
    for (int b = 0; b < BUCKETS; b++) issue(OP_READ, rand64(), rand64(), 6'(b));
    in_valid_i <= 1'b0;
    in_done = 1'b1;

    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (50) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      errors++;
      $display("%0d results never arrived", expected_q.size());
    end
    $display("covered %0d results: %0d matched completions, %0d drops, all buckets read",
             n_results, n_hits, n_drops);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
